// File: hw/rtl/nhbm_pkg.sv
// shared constants, command and status types and the hash step function
`default_nettype none

package nhbm_pkg;

  localparam int DEF_MAX_NAME_BYTES = 256;
  localparam int DEF_PASS_COUNT     = 3;

  localparam int                 WATCH_COUNT = 6;
  localparam int                 CFG_IDX_W   = 3;
  localparam int                 SLOT_W      = 3;
  localparam logic [31:0]        HASH_SEED   = 32'h8765_4321;

  localparam logic [31:0] WATCH_RESET [WATCH_COUNT] = '{
    32'h4A24_1C3E,
    32'h966D_0415,
    32'hAA33_1620,
    32'hC8F1_0976,
    32'hE251_7A14,
    32'hE5A0_5A00
  };

  typedef struct packed {
    logic store;       // input transaction accepted
    logic begin_hash;  // last byte accepted, seed the hash
    logic issue;       // read the next stored byte for the hash
    logic result_load; // capture hash and match into the output register
  } nhbm_cmd_t;

  typedef struct packed {
    logic last_issue;  // this read is the final byte of the final pass
  } nhbm_stat_t;

  // one byte update: lane byte becomes (lane xor b) - 1, wrapping
  function automatic logic [31:0] hash_step(input logic [31:0] w, input logic [1:0] lane,
                                            input logic [7:0] b);
    logic [31:0] r;
    logic [7:0]  s;
    r = w;
    s = w[lane*8 +: 8];
    r[lane*8 +: 8] = (s ^ b) - 8'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/name_hash_blacklist_match.sv
// Loading: one byte per cycle while in S_LOAD; input stalls from the last byte's
// transaction until the result is loaded, so a new name waits for the last result.
// Hashing: PASS_COUNT passes over the stored bytes through the single read port of
// the name store, one byte a cycle; S_DRAIN, then S_MATCH loads the output register.
// Reset (rst, synchronous): empties the name buffer and the output register and
// restores the six watch words to their reset values.
`default_nettype none

module name_hash_blacklist_match
  import nhbm_pkg::*;
#(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES,
  parameter int PASS_COUNT     = DEF_PASS_COUNT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           name_byte,
  input  wire logic                 final_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [31:0]               hash_word,
  output logic                      matched,
  output logic [SLOT_W-1:0]         match_slot,
  output logic                      too_long,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  nhbm_cmd_t  cmd;
  nhbm_stat_t stat;

  nhbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .final_byte (final_byte),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  nhbm_datapath #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES),
    .PASS_COUNT     (PASS_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .name_byte  (name_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .hash_word  (hash_word),
    .matched    (matched),
    .match_slot (match_slot),
    .too_long   (too_long)
  );

endmodule

`default_nettype wire

// File: hw/rtl/nhbm_ctrl.sv
// controller state machine: byte loading, hash passes, result hand-off
`default_nettype none

module nhbm_ctrl
  import nhbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       final_byte,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire nhbm_stat_t stat,
  output nhbm_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_HASH,
    S_DRAIN,
    S_MATCH
  } state_t;

  state_t state;
  logic   acc;
  logic   out_free;

  assign in_stall = (state != S_LOAD);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd.store       = acc;
    cmd.begin_hash  = acc && final_byte;
    cmd.issue       = (state == S_HASH);
    cmd.result_load = (state == S_MATCH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cmd.begin_hash) state <= S_HASH;
        end
        S_HASH: begin
          if (stat.last_issue) state <= S_DRAIN;
        end
        // last read data is folded in during this cycle
        S_DRAIN: begin
          state <= S_MATCH;
        end
        S_MATCH: begin
          if (out_free) state <= S_LOAD;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase

      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nhbm_datapath.sv
// datapath: name store, byte counters, hash register, watch words and output register
`default_nettype none

module nhbm_datapath
  import nhbm_pkg::*;
#(
  parameter int MAX_NAME_BYTES = DEF_MAX_NAME_BYTES,
  parameter int PASS_COUNT     = DEF_PASS_COUNT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [7:0]           name_byte,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire nhbm_cmd_t            cmd,
  output nhbm_stat_t                stat,
  output logic [31:0]               hash_word,
  output logic                      matched,
  output logic [SLOT_W-1:0]         match_slot,
  output logic                      too_long
);

  localparam int IDX_W  = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_NAME_BYTES + 1);
  localparam int PASS_W = (PASS_COUNT > 1) ? $clog2(PASS_COUNT) : 1;

  logic [7:0]        name_store [MAX_NAME_BYTES];
  logic [CNT_W-1:0]  byte_count;
  logic              overflow_seen;
  logic              store_full;

  logic [IDX_W-1:0]  rd_idx;
  logic [PASS_W-1:0] pass_cnt;
  logic [1:0]        lane;
  logic [1:0]        lane_d;
  logic              rd_pending;
  logic [7:0]        rd_data;
  logic              last_byte;
  logic              last_pass;
  logic [31:0]       hash_state;

  logic [31:0]       watch_word [WATCH_COUNT];
  logic              hit;
  logic [SLOT_W-1:0] slot;

  assign store_full = (byte_count == CNT_W'(MAX_NAME_BYTES));
  assign last_byte  = ((CNT_W'(rd_idx) + CNT_W'(1)) == byte_count);
  assign last_pass  = (pass_cnt == PASS_W'(PASS_COUNT - 1));
  assign lane       = 2'(pass_cnt) + 2'(rd_idx);

  assign stat.last_issue = cmd.issue && last_byte && last_pass;

  // name store
  always_ff @(posedge clk) begin
    if (cmd.store && !store_full) begin
      name_store[byte_count[IDX_W-1:0]] <= name_byte;
    end
    if (cmd.issue) begin
      rd_data <= name_store[rd_idx];
    end
  end

  // byte count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.result_load) begin
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.store) begin
      if (store_full) begin
        overflow_seen <= 1'b1;
      end else begin
        byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

  // hash walk: one read issued per cycle in S_HASH, its data applied in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      rd_idx     <= '0;
      pass_cnt   <= '0;
    end else if (cmd.begin_hash) begin
      rd_pending <= 1'b0;
      rd_idx     <= '0;
      pass_cnt   <= '0;
    end else begin
      rd_pending <= cmd.issue;
      if (cmd.issue) begin
        if (last_byte) begin
          rd_idx   <= '0;
          pass_cnt <= pass_cnt + PASS_W'(1);
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      lane_d <= lane;
    end
    if (cmd.begin_hash) begin
      hash_state <= HASH_SEED;
    end else if (rd_pending) begin
      hash_state <= hash_step(hash_state, lane_d, rd_data);
    end
  end

  // watch words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < WATCH_COUNT; k++) begin
        watch_word[k] <= WATCH_RESET[k];
      end
    end else if (cfg_we) begin
      for (int k = 0; k < WATCH_COUNT; k++) begin
        if (cfg_index == CFG_IDX_W'(k)) watch_word[k] <= cfg_data;
      end
    end
  end

  // lowest equal slot wins
  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int k = WATCH_COUNT - 1; k >= 0; k--) begin
      if (hash_state == watch_word[k]) begin
        hit  = 1'b1;
        slot = SLOT_W'(k);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      hash_word  <= hash_state;
      matched    <= hit;
      match_slot <= slot;
      too_long   <= overflow_seen;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nhbm_checker.sv
// port-level checks for the name hash block, bound to the top level
`default_nettype none

module nhbm_checker
  import nhbm_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 final_byte,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [31:0]          hash_word,
  input wire logic                 matched,
  input wire logic [SLOT_W-1:0]    match_slot,
  input wire logic                 too_long
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_word) && $stable(matched)
      && $stable(match_slot) && $stable(too_long))
    else $error("stalled result changed");

  a_slot_no_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !matched |-> match_slot == '0)
    else $error("match_slot set without a match");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> match_slot < SLOT_W'(WATCH_COUNT))
    else $error("match_slot beyond the watch list");

  // hashing starts right after the last byte, so input must stall
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_byte |=> in_stall)
    else $error("input taken while hashing");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

endmodule

bind name_hash_blacklist_match nhbm_checker u_nhbm_checker (.*);

`default_nettype wire
